/* rtl/scfp_pkg.sv */
// Shared types and constants of the serial command frame parser.
`timescale 1ns / 1ps

package scfp_pkg;

    localparam int MAX_BODY_DEF = 9;
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 4;
    localparam int KIND_W       = 2;
    localparam int PWR_W        = 7;
    localparam int COORD_W      = 32;
    localparam int CFG_IDX_W    = 3;
    localparam int OUT_DATA_W   = 1 + PWR_W + 2 * COORD_W;

    localparam logic [LEN_W-1:0] POWER_LEN    = LEN_W'(2);
    localparam logic [LEN_W-1:0] POSITION_LEN = LEN_W'(9);

    localparam logic [KIND_W-1:0] KIND_PAUSE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESUME   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POWER    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POSITION = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESUME   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POSITION = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] pause;
        logic [BYTE_W-1:0] resume;
        logic [BYTE_W-1:0] power;
        logic [BYTE_W-1:0] position;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        header:   8'd170,
        pause:    8'd1,
        resume:   8'd2,
        power:    8'd3,
        position: 8'd4
    };

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic                      tx_enabled;
        logic [PWR_W-1:0]          power_level;
        logic signed [COORD_W-1:0] latitude;
        logic signed [COORD_W-1:0] longitude;
    } t_result;

endpackage

/* rtl/scfp_parser.sv */
// Frame parser state, body store and command dispatch.
`timescale 1ns / 1ps

module scfp_parser #(
    parameter int MAX_BODY = scfp_pkg::MAX_BODY_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [scfp_pkg::BYTE_W-1:0] i_byte,
    input  scfp_pkg::t_cfg              i_cfg,
    output logic                        o_fire,
    output scfp_pkg::t_result           o_result
);
    import scfp_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY
    } t_phase;

    t_phase             r_phase;
    logic [LEN_W-1:0]   r_len;
    logic [LEN_W-1:0]   r_cnt;
    logic               r_tx;
    logic [BYTE_W-1:0]  r_store [MAX_BODY];

    logic [BYTE_W-1:0]  w_view  [MAX_BODY];
    logic [LEN_W-1:0]   n_cnt;
    logic               w_last;
    logic               w_hit;
    logic               w_len_bad;
    t_result            w_res;

    // The byte in flight takes the place of the entry it is about to fill, so the
    // dispatch sees the complete body on the cycle of the last byte.
    always_comb begin
        for (int k = 0; k < MAX_BODY; k++) begin
            w_view[k] = (r_cnt == LEN_W'(k)) ? i_byte : r_store[k];
        end
    end

    assign n_cnt     = r_cnt + 1'b1;
    assign w_last    = (n_cnt >= r_len);
    assign w_len_bad = (i_byte == '0) || (i_byte > BYTE_W'(MAX_BODY));

    always_comb begin
        w_hit            = 1'b0;
        w_res            = '0;
        w_res.tx_enabled = r_tx;
        if (w_view[0] == i_cfg.pause) begin
            w_hit            = 1'b1;
            w_res.kind       = KIND_PAUSE;
            w_res.tx_enabled = 1'b0;
        end else if (w_view[0] == i_cfg.resume) begin
            w_hit            = 1'b1;
            w_res.kind       = KIND_RESUME;
            w_res.tx_enabled = 1'b1;
        end else if (w_view[0] == i_cfg.power) begin
            w_res.kind        = KIND_POWER;
            w_res.power_level = w_view[1][PWR_W-1:0];
            w_hit             = (r_len == POWER_LEN) && !w_view[1][BYTE_W-1];
        end else if (w_view[0] == i_cfg.position) begin
            w_res.kind      = KIND_POSITION;
            w_res.latitude  = {w_view[4], w_view[3], w_view[2], w_view[1]};
            w_res.longitude = {w_view[8], w_view[7], w_view[6], w_view[5]};
            w_hit           = (r_len == POSITION_LEN);
        end
    end

    assign o_fire   = i_valid && (r_phase == PH_BODY) && w_last && w_hit;
    assign o_result = w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= '0;
            r_cnt   <= '0;
            r_tx    <= 1'b1;
        end else if (i_valid) begin
            unique case (r_phase)
                PH_LEN: begin
                    if (w_len_bad) begin
                        r_phase <= PH_HUNT;
                    end else begin
                        r_len   <= i_byte[LEN_W-1:0];
                        r_cnt   <= '0;
                        r_phase <= PH_BODY;
                    end
                end
                PH_BODY: begin
                    r_cnt <= n_cnt;
                    if (w_last) begin
                        r_phase <= PH_HUNT;
                        if (w_hit) begin
                            r_tx <= w_res.tx_enabled;
                        end
                    end
                end
                default: begin
                    r_phase <= (i_byte == i_cfg.header) ? PH_LEN : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_BODY; k++) begin
            if (i_valid && (r_phase == PH_BODY) && (r_cnt == LEN_W'(k))) begin
                r_store[k] <= i_byte;
            end
        end
    end

endmodule

/* rtl/serial_command_frame_parser_top.sv */
// Top level of the serial command frame parser: stream ports, registers, pipeline.
`timescale 1ns / 1ps

// The block takes one received byte per clock cycle and returns at most one event
// word per command frame. A byte enters an input register, and while the output
// register is free the parser updates its hunt, length and body state from it and
// writes any event into the output register, so an event passes both registers.
// Both stages move together whenever the output register is empty or being taken,
// which keeps the sustained rate at one byte per cycle; back pressure on the event
// side stalls byte intake only once both registers are full. A frame
// is the header byte, a length byte of 1 to MAX_BODY, and that many body bytes: an
// opcode followed by its arguments. Pause and resume report the transmit enable
// flag they leave behind, power set needs length 2 and a level below 128, position
// set needs length 9 and carries two little-endian signed 32-bit coordinates.
// Frames that fail these checks or carry an unknown opcode produce no event. The
// five 8-bit registers (header, pause, resume, power and position codes) are
// written through the configuration channel, which is always ready, and should
// only be changed while no byte is in flight.
module serial_command_frame_parser_top #(
    parameter int MAX_BODY = scfp_pkg::MAX_BODY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Received byte stream.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [scfp_pkg::BYTE_W-1:0]     i_s_tdata,   // [7:0] rx_byte
    // Event stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [scfp_pkg::OUT_DATA_W-1:0] o_m_tdata,   // [0] tx_enabled,
                                                         // [7:1] power_level,
                                                         // [39:8] latitude,
                                                         // [71:40] longitude
    output logic [scfp_pkg::KIND_W-1:0]     o_m_tuser,   // [1:0] event_kind
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [scfp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scfp_pkg::BYTE_W-1:0]     i_cfg_data
);
    import scfp_pkg::*;

    t_cfg              r_cfg;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    logic              w_advance;
    logic              w_fire;
    t_result           w_result;

    // The output register frees up when it is empty or its word is being taken;
    // only then does the input register hand its byte to the parser.
    assign w_advance  = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HEADER:   r_cfg.header   <= i_cfg_data;
                CFG_PAUSE:    r_cfg.pause    <= i_cfg_data;
                CFG_RESUME:   r_cfg.resume   <= i_cfg_data;
                CFG_POWER:    r_cfg.power    <= i_cfg_data;
                CFG_POSITION: r_cfg.position <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    scfp_parser #(
        .MAX_BODY (MAX_BODY)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid && w_advance),
        .i_byte   (r_in_byte),
        .i_cfg    (r_cfg),
        .o_fire   (w_fire),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {r_out.longitude, r_out.latitude, r_out.power_level,
                         r_out.tx_enabled};

    // Pause always leaves transmission off, resume always leaves it on.
    a_tx_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == KIND_PAUSE || o_m_tuser == KIND_RESUME)
        |-> (r_out.tx_enabled == (o_m_tuser == KIND_RESUME)))
        else $error("transmit enable flag does not match pause or resume event");

    // Fields that do not belong to the event kind are zero.
    a_unused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
        ((o_m_tuser == KIND_POWER) || (r_out.power_level == '0)) &&
        ((o_m_tuser == KIND_POSITION) || (r_out.latitude == '0 && r_out.longitude == '0)))
        else $error("event word carries data outside its kind");

    // Byte intake stalls only while both registers are full and the event is held.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("byte intake stalled while the pipeline has room");

    // An event word appears only after a byte moved into the parser.
    a_event_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_in_valid))
        else $error("event word without a parsed byte");

endmodule

/* bench/tb_serial_command_frame_parser_top.sv */
// Self-checking testbench of the serial command frame parser top level.
`timescale 1ns / 1ps

// The bench feeds received bytes into the slave stream and checks every event word
// that leaves the master stream. A behavioral copy of the parser runs inside the
// bench. It sees each byte at the clock edge where that byte is accepted, and it
// queues the event that the byte completes, if there is one. Each event word that
// the block delivers is compared field by field with the oldest queued event.
//
// The run starts with a short directed table at the reset register values. Rows
// whose outcome is obvious carry their expected event typed in. The random part
// then runs through several register settings, among them all zeros, extreme values and
// overlapping opcodes. Registers are only written once the event queue is empty and
// the pipeline has settled. The sender works in bursts with random gaps, and the
// receiver stalls on a pattern that changes from phase to phase.
module tb_serial_command_frame_parser_top;

    import scfp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE      = 8;     // Cycles for bytes still in the pipeline.
    localparam int BODY_MAX    = MAX_BODY_DEF;
    localparam int SHOW_MAX    = 10;

    // Indexes that select no register; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam t_result NO_EVT = '0;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN,
        PH_BODY
    } t_phase;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC,
        RDY_LONG
    } t_rdy_mode;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              lit;   // The event below is typed in, not predicted.
        t_result           evt;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [BYTE_W-1:0]     i_s_tdata   = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [KIND_W-1:0]     o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [BYTE_W-1:0]     i_cfg_data  = '0;

    serial_command_frame_parser_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow copy of the parser state and of the five registers, at reset values.
    t_phase            scan_phase = PH_HUNT;
    logic [LEN_W-1:0]  frame_len  = '0;
    logic [LEN_W-1:0]  body_cnt   = '0;
    logic [BYTE_W-1:0] body_buf [BODY_MAX];
    logic              tx_on      = 1'b1;
    t_cfg              regs       = CFG_RESET;

    t_result   event_q [$];    // Events owed by the block, oldest first.
    t_dir_row  dir_tab [$];
    t_result   got_evt;
    t_result   want_evt;
    int        fail_cnt   = 0;
    int        cycle_cnt  = 0;
    int        bytes_sent = 0;
    int        burst_left = 0;
    int        gap_max    = 0;
    t_rdy_mode rdy_mode   = RDY_ALWAYS;
    logic [7:0] rdy_tick  = '0;

    function automatic t_result evt(input logic [KIND_W-1:0] kind, input logic tx,
                                    input logic [PWR_W-1:0] pwr,
                                    input logic [COORD_W-1:0] lat,
                                    input logic [COORD_W-1:0] lon);
        t_result r;
        r.kind        = kind;
        r.tx_enabled  = tx;
        r.power_level = pwr;
        r.latitude    = lat;
        r.longitude   = lon;
        return r;
    endfunction

    // Advances the shadow parser by one byte and says whether the byte finished a
    // frame that reports an event.
    task automatic parse_byte(input logic [BYTE_W-1:0] b, output bit fired,
                              output t_result ev);
        logic [BYTE_W-1:0] op;
        fired = 1'b0;
        ev    = NO_EVT;
        case (scan_phase)
            PH_LEN: begin
                // A zero length or one beyond the body store drops the frame.
                if (b == 0 || b > BODY_MAX) begin
                    scan_phase = PH_HUNT;
                end else begin
                    frame_len  = b[LEN_W-1:0];
                    body_cnt   = '0;
                    scan_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (body_cnt < BODY_MAX) begin
                    body_buf[body_cnt] = b;
                end
                body_cnt = body_cnt + 1'b1;
                if (body_cnt >= frame_len) begin
                    scan_phase = PH_HUNT;
                    op = body_buf[0];
                    // The first matching opcode register wins.
                    if (op == regs.pause) begin
                        tx_on   = 1'b0;
                        ev.kind = KIND_PAUSE;
                        fired   = 1'b1;
                    end else if (op == regs.resume) begin
                        tx_on   = 1'b1;
                        ev.kind = KIND_RESUME;
                        fired   = 1'b1;
                    end else if (op == regs.power) begin
                        if (frame_len == POWER_LEN && !body_buf[1][7]) begin
                            ev.kind        = KIND_POWER;
                            ev.power_level = body_buf[1][PWR_W-1:0];
                            fired          = 1'b1;
                        end
                    end else if (op == regs.position) begin
                        if (frame_len == POSITION_LEN) begin
                            ev.kind      = KIND_POSITION;
                            ev.latitude  = {body_buf[4], body_buf[3], body_buf[2],
                                            body_buf[1]};
                            ev.longitude = {body_buf[8], body_buf[7], body_buf[6],
                                            body_buf[5]};
                            fired        = 1'b1;
                        end
                    end
                    if (fired) begin
                        ev.tx_enabled = tx_on;
                    end
                end
            end
            default: begin
                scan_phase = (b == regs.header) ? PH_LEN : PH_HUNT;
            end
        endcase
    endtask

    // Offers one byte, waits for it to be accepted and records what it owes. The
    // sender runs in bursts; when a burst is used up, a random gap may follow.
    task automatic send_byte(input logic [BYTE_W-1:0] b, input bit lit,
                             input t_result lit_evt);
        int      gap;
        bit      fired;
        t_result ev;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        parse_byte(b, fired, ev);
        if (lit) begin
            event_q.push_back(lit_evt);
        end else if (fired) begin
            event_q.push_back(ev);
        end
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic send_rand(input logic [BYTE_W-1:0] b);
        send_byte(b, 1'b0, NO_EVT);
    endtask

    task automatic dir(input logic [BYTE_W-1:0] b);
        dir_tab.push_back({b, 1'b0, NO_EVT});
    endtask

    task automatic dir_evt(input logic [BYTE_W-1:0] b, input t_result e);
        dir_tab.push_back({b, 1'b1, e});
    endtask

    // Stops the sender until every owed event has arrived, then lets the last
    // bytes, which may owe nothing, leave the pipeline.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (event_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_HEADER:   regs.header   = val;
            CFG_PAUSE:    regs.pause    = val;
            CFG_RESUME:   regs.resume   = val;
            CFG_POWER:    regs.power    = val;
            CFG_POSITION: regs.position = val;
            default: ;
        endcase
    endtask

    task automatic load_regs(input t_cfg c, input bit spare);
        drain();
        write_reg(CFG_HEADER, c.header);
        write_reg(CFG_PAUSE, c.pause);
        write_reg(CFG_RESUME, c.resume);
        write_reg(CFG_POWER, c.power);
        write_reg(CFG_POSITION, c.position);
        if (spare) begin
            write_reg(CFG_SPARE_LO, 8'($urandom));
            write_reg(CFG_SPARE_HI, 8'($urandom));
        end
        i_cfg_valid <= 1'b0;
    endtask

    // One random stimulus unit. Most units are well-formed frames with random
    // content; the rest are stray bytes, dropped lengths, frames with a random opcode
    // and frames that fail the length or level checks.
    task automatic random_frame();
        int                sel;
        int                len;
        int                i;
        logic [BYTE_W-1:0] op;
        logic [BYTE_W-1:0] arg;
        sel = $urandom_range(0, 99);
        if (sel < 10) begin
            repeat ($urandom_range(1, 4)) send_rand(8'($urandom));
        end else if (sel < 18) begin
            send_rand(regs.header);
            case ($urandom_range(0, 2))
                0:       send_rand(8'd0);
                1:       send_rand(8'($urandom_range(BODY_MAX + 1, 255)));
                default: send_rand(regs.header);
            endcase
        end else begin
            arg = 8'($urandom);
            if (sel < 34) begin
                op  = $urandom_range(0, 1) ? regs.pause : regs.resume;
                len = $urandom_range(1, BODY_MAX);
            end else if (sel < 58) begin
                op  = regs.power;
                len = ($urandom_range(0, 5) != 0) ? 2 : $urandom_range(1, BODY_MAX);
                // Keep most levels legal so that power events are frequent.
                if ($urandom_range(0, 3) != 0) begin
                    arg[7] = 1'b0;
                end
            end else if (sel < 88) begin
                op  = regs.position;
                len = ($urandom_range(0, 9) != 0) ? BODY_MAX : $urandom_range(1, 8);
            end else begin
                op  = 8'($urandom);
                len = $urandom_range(1, BODY_MAX);
            end
            send_rand(regs.header);
            send_rand(8'(len));
            send_rand(op);
            for (i = 1; i < len; i++) begin
                send_rand((i == 1) ? arg : 8'($urandom));
            end
        end
    endtask

    // Runs random units for about the given number of bytes, then finishes any
    // open frame so that the next register setting starts from the hunt.
    task automatic random_phase(input int nbytes, input int gaps, input t_rdy_mode mode);
        int stop_at;
        stop_at    = bytes_sent + nbytes;
        gap_max    = gaps;
        burst_left = 0;
        rdy_mode  <= mode;
        while (bytes_sent < stop_at) random_frame();
        while (scan_phase != PH_HUNT) send_rand(8'($urandom));
    endtask

    // The receiver stalls on its own pattern, chosen per phase.
    always @(posedge i_clk) begin
        rdy_tick <= rdy_tick + 1'b1;
        case (rdy_mode)
            RDY_ALWAYS:   i_m_tready <= 1'b1;
            RDY_RANDOM:   i_m_tready <= ($urandom_range(0, 3) != 0);
            RDY_PERIODIC: i_m_tready <= (rdy_tick[2:0] < 3'd5);
            default:      i_m_tready <= rdy_tick[4];
        endcase
    end

    // Event checker: every accepted word is matched against the oldest owed event.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_evt.kind        = o_m_tuser;
            got_evt.tx_enabled  = o_m_tdata[0];
            got_evt.power_level = o_m_tdata[7:1];
            got_evt.latitude    = o_m_tdata[39:8];
            got_evt.longitude   = o_m_tdata[71:40];
            if (event_q.size() == 0) begin
                fail_cnt = fail_cnt + 1;
                if (fail_cnt <= SHOW_MAX) begin
                    $display("unexpected event: kind=%0d tx=%0d pwr=%0d lat=%h lon=%h",
                             got_evt.kind, got_evt.tx_enabled, got_evt.power_level,
                             got_evt.latitude, got_evt.longitude);
                end
            end else begin
                want_evt = event_q.pop_front();
                if (got_evt.kind !== want_evt.kind
                        || got_evt.tx_enabled !== want_evt.tx_enabled
                        || got_evt.power_level !== want_evt.power_level
                        || got_evt.latitude !== want_evt.latitude
                        || got_evt.longitude !== want_evt.longitude) begin
                    fail_cnt = fail_cnt + 1;
                    if (fail_cnt <= SHOW_MAX) begin
                        $display("mismatch: expected kind=%0d tx=%0d pwr=%0d lat=%h lon=%h",
                                 want_evt.kind, want_evt.tx_enabled,
                                 want_evt.power_level, want_evt.latitude,
                                 want_evt.longitude);
                        $display("          actual   kind=%0d tx=%0d pwr=%0d lat=%h lon=%h",
                                 got_evt.kind, got_evt.tx_enabled, got_evt.power_level,
                                 got_evt.latitude, got_evt.longitude);
                    end
                end
            end
        end
    end

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_cfg c;
        int   i;

        // Directed table, run at the reset register values. The first frame is a
        // pause whose extra bytes are ignored, one of them equal to the header.
        dir(8'hAA); dir(8'h03); dir(8'h01); dir(8'hAA);
        dir_evt(8'h55, evt(KIND_PAUSE, 1'b0, 7'd0, 32'h0, 32'h0));
        dir(8'hAA); dir(8'h01);
        dir_evt(8'h02, evt(KIND_RESUME, 1'b1, 7'd0, 32'h0, 32'h0));
        // Highest legal power level, then a level with bit 7 set, which is refused.
        dir(8'hAA); dir(8'h02); dir(8'h03);
        dir_evt(8'h7F, evt(KIND_POWER, 1'b1, 7'd127, 32'h0, 32'h0));
        dir(8'hAA); dir(8'h02); dir(8'h03); dir(8'h80);
        // A zero length, then the header byte itself in the length slot.
        dir(8'hAA); dir(8'h00);
        dir(8'hAA); dir(8'hAA);
        // Position with the most negative latitude and the most positive longitude.
        dir(8'hAA); dir(8'h09); dir(8'h04);
        dir(8'h00); dir(8'h00); dir(8'h00); dir(8'h80);
        dir(8'hFF); dir(8'hFF); dir(8'hFF);
        dir_evt(8'h7F, evt(KIND_POSITION, 1'b1, 7'd0, 32'h8000_0000, 32'h7FFF_FFFF));

        for (i = 0; i < BODY_MAX; i++) begin
            body_buf[i] = '0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        rdy_mode <= RDY_RANDOM;
        gap_max = 4;
        foreach (dir_tab[i]) begin
            send_byte(dir_tab[i].rx, dir_tab[i].lit, dir_tab[i].evt);
        end

        // Random traffic at the reset values, sender in bursts, receiver random.
        random_phase(150, 6, RDY_RANDOM);

        // Every register at zero, so every opcode register decodes as a pause; the spare indexes
        // are written too. No idling on either side.
        c = '0;
        load_regs(c, 1'b1);
        random_phase(90, 0, RDY_ALWAYS);

        // Registers at extreme and boundary values.
        c = '{header: 8'hFF, pause: 8'h80, resume: 8'h7F, power: 8'hFF, position: 8'h00};
        load_regs(c, 1'b0);
        random_phase(120, 3, RDY_PERIODIC);

        // Random header with overlapping opcodes: resume shadows power and pause
        // shadows position.
        c.header   = 8'($urandom);
        c.pause    = 8'($urandom);
        c.resume   = 8'($urandom);
        c.power    = c.resume;
        c.position = c.pause;
        load_regs(c, 1'b0);
        random_phase(100, 8, RDY_LONG);

        // Fully random registers.
        c.header   = 8'($urandom);
        c.pause    = 8'($urandom);
        c.resume   = 8'($urandom);
        c.power    = 8'($urandom);
        c.position = 8'($urandom);
        load_regs(c, 1'b0);
        random_phase(140, 5, RDY_RANDOM);

        drain();
        repeat (SETTLE) @(posedge i_clk);

        if (event_q.size() != 0) begin
            fail_cnt = fail_cnt + 1;
            $display("%0d expected events never arrived", event_q.size());
        end
        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
